// ===== sv/rlpg_pkg.sv =====
// Shared types, codes and lookup tables for the RGB LED pattern generator.
// Has no dependencies. The top level imports it.
`default_nettype none

package rlpg_pkg;

  localparam int SINE_ENTRIES    = 64;
  localparam int RAINBOW_ENTRIES = 64;
  localparam int WAVE_W          = $clog2(SINE_ENTRIES);
  localparam int HUE_W           = $clog2(RAINBOW_ENTRIES);

  localparam int MODE_W     = 4;
  localparam int DUR_W      = 16;
  localparam int COLOR_W    = 8;
  localparam int SINCE_W    = 16;
  localparam int INTERVAL_W = 10;
  localparam int REMAIN_W   = 26;

  // Stream payload widths: input tdata carries anim_mode, duration_seconds,
  // rand_a, rand_b (36 bits, padded to 40); output tdata carries the RGB drive.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;

  localparam logic [MODE_W-1:0] MODE_OFF       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_ACK       = 4'd1;
  localparam logic [MODE_W-1:0] MODE_NACK      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_REDBLUE   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_TRAFFIC   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_MATRIX    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_RAINBOW   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_PULSERED  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_PULSEBLUE = 4'd8;
  localparam logic [MODE_W-1:0] MODE_STROBE    = 4'd9;
  localparam logic [MODE_W-1:0] MODE_FIRE      = 4'd10;
  localparam logic [MODE_W-1:0] MODE_OCEAN     = 4'd11;
  localparam logic [MODE_W-1:0] MODE_THINKING  = 4'd12;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [7:0]            STEP_LAST   = 8'd191;
  localparam logic [SINCE_W-1:0]    SINCE_MAX   = 16'hFFFF;
  localparam logic [REMAIN_W-1:0]   BRIEF_MS    = 26'd300;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 10'd500;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } rgb_t;

  localparam logic [INTERVAL_W-1:0] PERIOD_TAB [13] = '{
    10'd0, 10'd100, 10'd100, 10'd150, 10'd800, 10'd50, 10'd50,
    10'd30, 10'd30, 10'd100, 10'd80, 10'd40, 10'd200
  };

  localparam logic [7:0] SINE_TAB [SINE_ENTRIES] = '{
    8'd128, 8'd140, 8'd152, 8'd164, 8'd176, 8'd187, 8'd198, 8'd208,
    8'd218, 8'd227, 8'd235, 8'd242, 8'd248, 8'd252, 8'd255, 8'd255,
    8'd252, 8'd248, 8'd242, 8'd235, 8'd227, 8'd218, 8'd208, 8'd198,
    8'd187, 8'd176, 8'd164, 8'd152, 8'd140, 8'd128, 8'd115, 8'd103,
    8'd91,  8'd79,  8'd68,  8'd57,  8'd47,  8'd37,  8'd28,  8'd20,
    8'd13,  8'd7,   8'd3,   8'd0,   8'd0,   8'd3,   8'd7,   8'd13,
    8'd20,  8'd28,  8'd37,  8'd47,  8'd57,  8'd68,  8'd79,  8'd91,
    8'd103, 8'd115, 8'd128, 8'd140, 8'd152, 8'd164, 8'd176, 8'd187
  };

  // Hue wheel, each entry written as red, green, blue from the high byte down.
  localparam logic [23:0] HUE_TAB [RAINBOW_ENTRIES] = '{
    24'hFF0000, 24'hFF1000, 24'hFF2000, 24'hFF3000,
    24'hFF4000, 24'hFF5000, 24'hFF6000, 24'hFF7000,
    24'hFF8000, 24'hFF9000, 24'hFFA000, 24'hFFB000,
    24'hFFC000, 24'hFFD000, 24'hFFE000, 24'hFFF000,
    24'hFFFF00, 24'hE0FF00, 24'hC0FF00, 24'hA0FF00,
    24'h80FF00, 24'h60FF00, 24'h40FF00, 24'h20FF00,
    24'h10FF00, 24'h00FF00, 24'h00FF20, 24'h00FF40,
    24'h00FF60, 24'h00FF80, 24'h00FFA0, 24'h00FFC0,
    24'h00FFE0, 24'h00FFFF, 24'h00E0FF, 24'h00C0FF,
    24'h00A0FF, 24'h0080FF, 24'h0060FF, 24'h0040FF,
    24'h0020FF, 24'h0010FF, 24'h0000FF, 24'h1000FF,
    24'h2000FF, 24'h3000FF, 24'h4000FF, 24'h5000FF,
    24'h6000FF, 24'h7000FF, 24'h8000FF, 24'h9000FF,
    24'hA000FF, 24'hB000FF, 24'hC000FF, 24'hD000FF,
    24'hE000FF, 24'hF000FF, 24'hFF00FF, 24'hFF00E0,
    24'hFF00C0, 24'hFF00A0, 24'hFF0080, 24'hFF0060
  };

endpackage

`default_nettype wire

// ===== sv/rgb_led_pattern_generator.sv =====
// RGB LED pattern generator: one result beat for every input beat.
// Depends on rlpg_pkg for codes, widths and the sine and hue tables.
//
// Usage:
//   The s_ channel takes items. s_tuser[0] is the op: 0 is a one millisecond
//   tick, 1 starts a pattern given by anim_mode and duration_seconds. The m_
//   channel returns the RGB drive levels and, in m_tuser[0], the animating
//   flag. The cfg_ channel writes invert_output (1 for a common-anode LED).
//   Each result is registered and appears on m_ in the cycle after its beat
//   is accepted. Throughput is one beat per cycle while m_ is not stalled;
//   all the per-item work is one level of table reads and small adds ahead
//   of the result register; pattern state is updated at the accepting edge.
//   The result register doubles as the skid stage: s_tready stays high while
//   m_ is empty or being drained, so a beat is taken in the same cycle an
//   older result leaves. When the receiver stalls, s_tready drops and the
//   held result stays on m_ unchanged.
//   Reset clears the pattern state (mode off, interval 500 ms, color black),
//   sets invert_output to 1 and empties the result register. The cfg_ port
//   is always ready and should be written only while the block is idle.
`default_nettype none

module rgb_led_pattern_generator (
  input  logic                            clk,
  input  logic                            rst,
  // Input beat. tdata from bit 0: anim_mode[3:0], duration_seconds[15:0],
  // rand_a[7:0], rand_b[7:0], 4 zero bits.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rlpg_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,    // op
  // Result beat. tdata from bit 0: red_drive, green_drive, blue_drive.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rlpg_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                            m_tuser,    // animating
  // Register write: invert_output.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);

  import rlpg_pkg::*;

  logic                  invert_output;
  logic [MODE_W-1:0]     mode, mode_next;
  logic [7:0]            step_count, step_count_next;
  logic [WAVE_W-1:0]     wave_index, wave_index_next;
  logic [WAVE_W-1:0]     wave_index_fast, wave_index_fast_next;
  logic [SINCE_W-1:0]    since_update_ms, since_update_ms_next;
  logic [INTERVAL_W-1:0] interval_ms, interval_ms_next;
  logic [REMAIN_W-1:0]   remaining_ms, remaining_ms_next;
  logic                  end_armed, end_armed_next;
  rgb_t                  color_latch, color_latch_next;

  logic                  s_accept;
  logic                  op;
  logic [MODE_W-1:0]     anim_mode;
  logic [DUR_W-1:0]      duration_seconds;
  logic [7:0]            rand_a;
  logic [7:0]            rand_b;

  logic [MODE_W-1:0]     start_mode;
  logic [SINCE_W-1:0]    since_inc;
  logic [7:0]            step_bump;
  logic [15:0]           step_prod;
  logic [7:0]            step_div3;
  logic [7:0]            step_rem3_full;
  logic [1:0]            step_rem3;
  logic [7:0]            sine_slow;
  logic [7:0]            sine_fast;
  logic [15:0]           ocean_scaled;
  logic [15:0]           ocean_round;
  logic [7:0]            ocean_green;
  logic [7:0]            thinking_lvl;
  logic [7:0]            fire_red_mod;
  logic [7:0]            fire_green;
  logic [23:0]           hue_entry;
  rgb_t                  paint_color;
  rgb_t                  drive;

  assign s_accept         = s_tvalid && s_tready;
  assign s_tready         = !m_tvalid || m_tready;
  assign cfg_ready        = 1'b1;

  assign op               = s_tuser;
  assign anim_mode        = s_tdata[3:0];
  assign duration_seconds = s_tdata[19:4];
  assign rand_a           = s_tdata[27:20];
  assign rand_b           = s_tdata[35:28];

  // Pattern helpers, taken from the present state and the input beat.
  assign start_mode = (anim_mode > MODE_THINKING) ? MODE_OFF : anim_mode;
  assign since_inc  = (since_update_ms == SINCE_MAX) ? since_update_ms
                                                     : since_update_ms + 16'd1;
  assign step_bump  = (step_count == STEP_LAST) ? 8'd0 : step_count + 8'd1;

  // step / 3 by reciprocal (171 / 512), exact for all step values in range.
  assign step_prod      = 16'(step_count) * 16'd171;
  assign step_div3      = {1'b0, step_prod[15:9]};
  assign step_rem3_full = step_count - {step_div3[6:0], 1'b0} - step_div3;
  assign step_rem3      = step_rem3_full[1:0];

  assign sine_slow = SINE_TAB[wave_index];
  assign sine_fast = SINE_TAB[wave_index_fast];

  // sine * 100 / 255 with the divide done as (p + p/256 + 1) / 256.
  assign ocean_scaled = {2'b0, sine_fast, 6'b0} + {3'b0, sine_fast, 5'b0}
                      + {6'b0, sine_fast, 2'b0};
  assign ocean_round  = ocean_scaled + {8'b0, ocean_scaled[15:8]} + 16'd1;
  assign ocean_green  = ocean_round[15:8];

  always_comb begin
    case (step_rem3)
      2'd0:    thinking_lvl = 8'd108;
      2'd1:    thinking_lvl = 8'd180;
      default: thinking_lvl = 8'd72;
    endcase
  end

  always_comb begin
    if (rand_a >= 8'd224) begin
      fire_red_mod = rand_a - 8'd224;
    end else if (rand_a >= 8'd168) begin
      fire_red_mod = rand_a - 8'd168;
    end else if (rand_a >= 8'd112) begin
      fire_red_mod = rand_a - 8'd112;
    end else if (rand_a >= 8'd56) begin
      fire_red_mod = rand_a - 8'd56;
    end else begin
      fire_red_mod = rand_a;
    end
    if (rand_b >= 8'd200) begin
      fire_green = rand_b - 8'd200;
    end else if (rand_b >= 8'd100) begin
      fire_green = rand_b - 8'd100;
    end else begin
      fire_green = rand_b;
    end
  end

  assign hue_entry = HUE_TAB[step_count[HUE_W-1:0]];

  always_comb begin
    mode_next            = mode;
    step_count_next      = step_count;
    wave_index_next      = wave_index;
    wave_index_fast_next = wave_index_fast;
    since_update_ms_next = since_update_ms;
    interval_ms_next     = interval_ms;
    remaining_ms_next    = remaining_ms;
    end_armed_next       = end_armed;
    color_latch_next     = color_latch;
    paint_color          = '0;

    if (op == OP_START) begin
      mode_next            = start_mode;
      step_count_next      = 8'd0;
      wave_index_next      = '0;
      wave_index_fast_next = '0;
      since_update_ms_next = SINCE_MAX;
      if (start_mode == MODE_OFF) begin
        end_armed_next   = 1'b0;
        color_latch_next = '0;
      end else begin
        interval_ms_next = PERIOD_TAB[start_mode];
        if (start_mode == MODE_ACK || start_mode == MODE_NACK) begin
          remaining_ms_next = BRIEF_MS;
          end_armed_next    = 1'b1;
        end else if (duration_seconds != '0) begin
          remaining_ms_next = REMAIN_W'(duration_seconds * 26'd1000);
          end_armed_next    = 1'b1;
        end else begin
          remaining_ms_next = '0;
          end_armed_next    = 1'b0;
        end
      end
    end else begin
      since_update_ms_next = since_inc;
      if (end_armed && remaining_ms == '0) begin
        // The armed run time has passed.
        mode_next        = MODE_OFF;
        end_armed_next   = 1'b0;
        color_latch_next = '0;
      end else begin
        if (end_armed) begin
          remaining_ms_next = remaining_ms - 26'd1;
        end
        if (since_inc >= {6'b0, interval_ms}) begin
          since_update_ms_next = '0;
          case (mode) inside
            MODE_ACK, MODE_NACK: begin
              if (step_count == 8'd0) begin
                paint_color.red   = (mode == MODE_ACK) ? 8'd0 : 8'd64;
                paint_color.green = (mode == MODE_ACK) ? 8'd64 : 8'd0;
                color_latch_next  = paint_color;
              end else if (step_count == 8'd1) begin
                color_latch_next = '0;
                mode_next        = MODE_OFF;
                end_armed_next   = 1'b0;
              end
              step_count_next = step_bump;
            end
            MODE_REDBLUE: begin
              if (!step_count[0]) begin
                paint_color.red = 8'd255;
              end else begin
                paint_color.blue = 8'd255;
              end
              color_latch_next = paint_color;
              step_count_next  = step_bump;
            end
            MODE_TRAFFIC: begin
              paint_color.red   = (step_rem3 != 2'd1) ? 8'd255 : 8'd0;
              paint_color.green = (step_rem3 != 2'd0) ? 8'd255 : 8'd0;
              color_latch_next  = paint_color;
              step_count_next   = step_bump;
            end
            MODE_MATRIX: begin
              paint_color.green = sine_slow;
              color_latch_next  = paint_color;
              wave_index_next   = wave_index + WAVE_W'(1);
            end
            MODE_RAINBOW: begin
              paint_color.red   = hue_entry[23:16];
              paint_color.green = hue_entry[15:8];
              paint_color.blue  = hue_entry[7:0];
              color_latch_next  = paint_color;
              step_count_next   = step_bump;
            end
            MODE_PULSERED, MODE_PULSEBLUE: begin
              if (mode == MODE_PULSERED) begin
                paint_color.red = sine_slow;
              end else begin
                paint_color.blue = sine_slow;
              end
              color_latch_next = paint_color;
              wave_index_next  = wave_index + WAVE_W'(2);
            end
            MODE_STROBE: begin
              if (!step_count[0]) begin
                paint_color = '1;
              end
              color_latch_next = paint_color;
              step_count_next  = step_bump;
            end
            MODE_FIRE: begin
              paint_color.red   = fire_red_mod + 8'd200;
              paint_color.green = fire_green;
              color_latch_next  = paint_color;
            end
            MODE_OCEAN: begin
              paint_color.green    = ocean_green;
              paint_color.blue     = sine_slow;
              color_latch_next     = paint_color;
              wave_index_next      = wave_index + WAVE_W'(1);
              wave_index_fast_next = wave_index_fast + WAVE_W'(2);
            end
            MODE_THINKING: begin
              case (step_div3[1:0])
                2'd0:    paint_color.green = thinking_lvl;
                2'd1:    paint_color.red   = thinking_lvl;
                2'd2: begin
                  paint_color.red   = thinking_lvl;
                  paint_color.green = thinking_lvl;
                end
                default: paint_color.blue  = thinking_lvl;
              endcase
              color_latch_next = paint_color;
              step_count_next  = step_bump;
            end
            default: begin
              color_latch_next = '0;
            end
          endcase
        end
      end
    end
  end

  assign drive = invert_output ? ~color_latch_next : color_latch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_output <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      invert_output <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_OFF;
      step_count      <= 8'd0;
      wave_index      <= '0;
      wave_index_fast <= '0;
      since_update_ms <= '0;
      interval_ms     <= INTERVAL_RST;
      remaining_ms    <= '0;
      end_armed       <= 1'b0;
      color_latch     <= '0;
    end else if (s_accept) begin
      mode            <= mode_next;
      step_count      <= step_count_next;
      wave_index      <= wave_index_next;
      wave_index_fast <= wave_index_fast_next;
      since_update_ms <= since_update_ms_next;
      interval_ms     <= interval_ms_next;
      remaining_ms    <= remaining_ms_next;
      end_armed       <= end_armed_next;
      color_latch     <= color_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {drive.blue, drive.green, drive.red};
      m_tuser <= (mode_next != MODE_OFF);
    end
  end

  // An armed end time only exists while a pattern runs.
  a_armed_needs_mode: assert property (@(posedge clk) disable iff (rst)
    end_armed |-> (mode != MODE_OFF))
    else $error("end time armed while mode is off");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    step_count <= STEP_LAST)
    else $error("step counter beyond wrap point");

  a_interval_nonzero: assert property (@(posedge clk) disable iff (rst)
    interval_ms != '0)
    else $error("update interval loaded as zero");

  a_start_forces_update: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tuser == OP_START) |=> (since_update_ms == SINCE_MAX))
    else $error("start beat did not force an update on the next tick");

  a_result_follows_beat: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (m_tvalid && m_tuser == (mode != MODE_OFF)))
    else $error("result beat missing or animating flag out of step");

endmodule

`default_nettype wire
